/* src/assert_macros.svh */
// assertion macros used by the top-level rtl file of the event sequence watchdog
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/eswd_pkg.sv */
// types, codes and constants of the event sequence watchdog
// no dependencies; imported by every module of the block but eswd_row_mem
`timescale 1ns / 1ps
`default_nettype none

package eswd_pkg;

	localparam int NODES_DEF     = 64;
	localparam int EDGES_DEF     = 4;
	localparam int TIME_BITS_DEF = 16;

	localparam int NODE_W = 6;
	localparam int SLOT_W = 2;
	localparam int RULE_W = 4;
	localparam int DL_W   = 16;
	localparam int EL_W   = 16;

	localparam int IN_DATA_W  = 40;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 32;
	localparam int OUT_USER_W = 4;

	typedef enum logic [1:0] {
		OP_WR_EDGE  = 2'd0,
		OP_WR_FLAGS = 2'd1,
		OP_EVENT    = 2'd2,
		OP_TICK     = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		KIND_INTERRUPTED = 3'd0,
		KIND_ENTRY       = 3'd1,
		KIND_ACTIVATED   = 3'd2,
		KIND_COMPLETED   = 3'd3,
		KIND_TIMEOUT     = 3'd4
	} kind_t;

	// one edge slot, valid in the lowest bit
	typedef struct packed {
		logic [RULE_W-1:0] rule;
		logic [DL_W-1:0]   deadline;
		logic [NODE_W-1:0] target;
		logic              valid;
	} edge_t;

	// per-node flags, entry in the lowest bit
	typedef struct packed {
		logic [RULE_W-1:0] rule;
		logic              completion;
		logic              entry;
	} flags_t;

	localparam int EDGE_W = $bits(edge_t);
	localparam int FLAG_W = $bits(flags_t);

	typedef struct packed {
		op_t               op;
		logic [NODE_W-1:0] node;
		logic [SLOT_W-1:0] slot;
		logic              edge_valid;
		logic [NODE_W-1:0] target;
		logic [DL_W-1:0]   deadline;
		logic [RULE_W-1:0] rule;
		logic              is_entry;
		logic              is_completion;
	} item_t;

	typedef struct packed {
		kind_t             kind;
		logic              rule_named;
		logic [RULE_W-1:0] rule_id;
		logic [NODE_W-1:0] event_node;
		logic [EL_W-1:0]   elapsed;
		logic              last;
	} res_t;

endpackage

`default_nettype wire

/* src/event_sequence_watchdog_top.sv */
// channel   direction  tdata                                          tuser
// s_axis    in         node slot edge_valid target deadline rule      op
//                      is_entry is_completion
// m_axis    out        rule_id event_node elapsed                     kind rule_named
//
// after reset a clearing pass writes every node row once, with s_axis_tready low
// edge and flag writes pass through accept, row read and write back; ticks through
// accept and tick update, plus a result emit when a timeout result goes out
// a node event passes accept, row read, event row capture and decision, then a slot-serial
// deadline scan over the edge slots when a node is entered, then one emit step per result
// a new item is taken while the last result still waits in the output register
// depends on eswd_pkg, eswd_row_mem, eswd_out_buf, eswd_ctrl and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module event_sequence_watchdog_top #(
	parameter int NODES          = eswd_pkg::NODES_DEF,
	parameter int EDGES_PER_NODE = eswd_pkg::EDGES_DEF,
	parameter int TIME_BITS      = eswd_pkg::TIME_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// node, slot, edge_valid, target, deadline, rule, is_entry, is_completion, zero fill
	input  logic [eswd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// op
	input  logic [eswd_pkg::IN_USER_W-1:0]  s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// rule_id, event_node, elapsed, zero fill
	output logic [eswd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// kind, rule_named
	output logic [eswd_pkg::OUT_USER_W-1:0] m_axis_tuser,
	output logic                            m_axis_tlast
);

	import eswd_pkg::*;

	localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int RW = FLAG_W + EDGES_PER_NODE * EDGE_W;

	item_t          item;
	logic           mem_we;
	logic [AW-1:0]  mem_waddr;
	logic [RW-1:0]  mem_wdata;
	logic [AW-1:0]  mem_raddr;
	logic [RW-1:0]  mem_rdata;
	logic           push_valid;
	logic           push_ready;
	res_t           push_res;

	always_comb begin
		item.op            = op_t'(s_axis_tuser);
		item.node          = s_axis_tdata[5:0];
		item.slot          = s_axis_tdata[7:6];
		item.edge_valid    = s_axis_tdata[8];
		item.target        = s_axis_tdata[14:9];
		item.deadline      = s_axis_tdata[30:15];
		item.rule          = s_axis_tdata[34:31];
		item.is_entry      = s_axis_tdata[35];
		item.is_completion = s_axis_tdata[36];
	end

	eswd_row_mem #(
		.DEPTH (NODES),
		.AW    (AW),
		.W     (RW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	eswd_ctrl #(
		.NODES          (NODES),
		.EDGES_PER_NODE (EDGES_PER_NODE),
		.TIME_BITS      (TIME_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.item       (item),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_res   (push_res)
	);

	eswd_out_buf u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_res      (push_res),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// while the first of two results waits, the sequencer still holds the second
	`ASSERT_IMPLY(a_pair_blocks_input, clk, arst_n, m_axis_tvalid && !m_axis_tlast, !s_axis_tready, "input taken between two results of one item")

	// an interruption is always followed by the entry report of the same item
	`ASSERT_IMPLY(a_interrupt_not_last, clk, arst_n, m_axis_tvalid && m_axis_tuser[2:0] == KIND_INTERRUPTED, !m_axis_tlast, "interruption marked as final result")

	// an edge write never produces a result transfer
	`ASSERT_NEXT(a_write_silent, clk, arst_n, s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_WR_EDGE, !push_valid ##1 !push_valid, "edge write produced a result")

endmodule

`default_nettype wire

/* src/eswd_row_mem.sv */
// node row memory: flags and all edge slots of one node per row
// one write port, one read port with registered read data; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module eswd_row_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int W     = 114
) (
	input  logic         clk,
	input  logic         we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0] rdata
);

	logic [W-1:0] ram_q [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			ram_q[waddr] <= wdata;
		end
		rdata_q <= ram_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* src/eswd_out_buf.sv */
// result register between the sequencer and the master stream port
// depends on eswd_pkg for the result struct and field widths
`timescale 1ns / 1ps
`default_nettype none

module eswd_out_buf (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push_valid,
	output logic                                push_ready,
	input  eswd_pkg::res_t                      push_res,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// rule_id, event_node, elapsed, zero fill
	output logic [eswd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	// kind, rule_named
	output logic [eswd_pkg::OUT_USER_W-1:0]     m_axis_tuser,
	output logic                                m_axis_tlast
);

	import eswd_pkg::*;

	localparam int PAD_W = OUT_DATA_W - EL_W - NODE_W - RULE_W;

	logic valid_q;
	res_t res_q;

	assign push_ready = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push_ready) begin
			valid_q <= push_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (push_valid && push_ready) begin
			res_q <= push_res;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, res_q.elapsed, res_q.event_node, res_q.rule_id};
	assign m_axis_tuser  = {res_q.rule_named, res_q.kind};
	assign m_axis_tlast  = res_q.last;

endmodule

`default_nettype wire

/* src/eswd_ctrl.sv */
// sequencer: reset clearing pass, row read-modify-write, event decision, deadline scan, ticks, result emission
// depends on eswd_pkg; drives eswd_row_mem and eswd_out_buf
`timescale 1ns / 1ps
`default_nettype none

module eswd_ctrl #(
	parameter int NODES          = eswd_pkg::NODES_DEF,
	parameter int EDGES_PER_NODE = eswd_pkg::EDGES_DEF,
	parameter int TIME_BITS      = eswd_pkg::TIME_BITS_DEF,
	localparam int AW            = (NODES > 1) ? $clog2(NODES) : 1,
	localparam int RW            = eswd_pkg::FLAG_W + EDGES_PER_NODE * eswd_pkg::EDGE_W
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  eswd_pkg::item_t item,
	output logic            mem_we,
	output logic [AW-1:0]   mem_waddr,
	output logic [RW-1:0]   mem_wdata,
	output logic [AW-1:0]   mem_raddr,
	input  logic [RW-1:0]   mem_rdata,
	output logic            push_valid,
	input  logic            push_ready,
	output eswd_pkg::res_t  push_res
);

	import eswd_pkg::*;

	localparam int SW = (EDGES_PER_NODE > 1) ? $clog2(EDGES_PER_NODE) : 1;
	localparam int CW = (TIME_BITS > DL_W) ? TIME_BITS : DL_W;
	localparam logic [TIME_BITS-1:0] SAT = '1;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_READ, S_RMW, S_EV_B, S_EV_C, S_MIN, S_TICK, S_EMIT
	} state_t;

	state_t                 state_q;
	item_t                  item_q;
	logic [AW-1:0]          clr_q;
	logic                   active_q;
	logic [NODE_W-1:0]      cur_q;
	logic [TIME_BITS-1:0]   since_q;
	logic                   thr_valid_q;
	logic [DL_W-1:0]        thr_q;
	logic [RW-1:0]          rown_q;
	res_t                   res_q [2];
	logic                   emit_q;
	logic [SW-1:0]          scan_q;

	logic                   node_ok;
	logic                   cur_ok;
	logic                   slot_ok;
	logic                   wr_ok;
	logic [RW-1:0]          row_mod;
	logic [RW-1:0]          rowc;
	flags_t                 flags_n;
	logic                   any_n;
	logic                   found;
	logic [RULE_W-1:0]      mrule;
	edge_t                  sedge;
	logic [TIME_BITS-1:0]   since_n;
	logic                   tick_fire;

	function automatic res_t mk_res(kind_t k, logic named, logic [RULE_W-1:0] r,
	                                logic [NODE_W-1:0] n, logic [EL_W-1:0] el, logic lst);
		res_t x;
		x.kind       = k;
		x.rule_named = named;
		x.rule_id    = r;
		x.event_node = n;
		x.elapsed    = el;
		x.last       = lst;
		return x;
	endfunction

	assign node_ok = int'(item_q.node) < NODES;
	assign cur_ok  = int'(cur_q) < NODES;
	assign slot_ok = int'(item_q.slot) < EDGES_PER_NODE;
	assign wr_ok   = node_ok && (item_q.op == OP_WR_FLAGS || slot_ok);

	// merge a write item into the row just read back
	always_comb begin
		edge_t  ne;
		flags_t nf;
		ne.valid    = item_q.edge_valid;
		ne.target   = item_q.target;
		ne.deadline = item_q.deadline;
		ne.rule     = item_q.rule;
		nf.entry      = item_q.is_entry;
		nf.completion = item_q.is_completion;
		nf.rule       = item_q.rule;
		row_mod = mem_rdata;
		if (item_q.op == OP_WR_FLAGS) begin
			row_mod[FLAG_W-1:0] = nf;
		end else begin
			for (int s = 0; s < EDGES_PER_NODE; s++) begin
				if (int'(item_q.slot) == s) begin
					row_mod[FLAG_W + s*EDGE_W +: EDGE_W] = ne;
				end
			end
		end
	end

	// event decision: flags and edges of the event node, first matching edge of the current node
	always_comb begin
		edge_t e;
		rowc    = (active_q && cur_ok) ? mem_rdata : '0;
		flags_n = flags_t'(rown_q[FLAG_W-1:0]);
		any_n   = 1'b0;
		found   = 1'b0;
		mrule   = '0;
		for (int s = 0; s < EDGES_PER_NODE; s++) begin
			e     = edge_t'(rown_q[FLAG_W + s*EDGE_W +: EDGE_W]);
			any_n = any_n | e.valid;
		end
		for (int s = 0; s < EDGES_PER_NODE; s++) begin
			e = edge_t'(rowc[FLAG_W + s*EDGE_W +: EDGE_W]);
			if (!found && e.valid && e.target == item_q.node) begin
				found = 1'b1;
				mrule = e.rule;
			end
		end
	end

	assign sedge     = edge_t'(rown_q[FLAG_W + int'(scan_q)*EDGE_W +: EDGE_W]);
	assign since_n   = (since_q == SAT) ? since_q : since_q + 1'b1;
	assign tick_fire = thr_valid_q && (CW'(since_n) > CW'(thr_q));

	assign in_ready   = (state_q == S_IDLE);
	assign mem_we     = (state_q == S_CLR) || (state_q == S_RMW && wr_ok);
	assign mem_waddr  = (state_q == S_CLR) ? clr_q : AW'(item_q.node);
	assign mem_wdata  = (state_q == S_CLR) ? '0 : row_mod;
	assign mem_raddr  = (state_q == S_EV_B) ? AW'(cur_q) : AW'(item_q.node);
	assign push_valid = (state_q == S_EMIT);
	assign push_res   = res_q[emit_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			item_q      <= '0;
			clr_q       <= '0;
			active_q    <= 1'b0;
			cur_q       <= '0;
			since_q     <= '0;
			thr_valid_q <= 1'b0;
			thr_q       <= '0;
			rown_q      <= '0;
			res_q       <= '{default: '0};
			emit_q      <= 1'b0;
			scan_q      <= '0;
		end else begin
			case (state_q)
				S_CLR: begin
					if (clr_q == AW'(NODES - 1)) begin
						state_q <= S_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						item_q  <= item;
						state_q <= (item.op == OP_TICK) ? S_TICK : S_READ;
					end
				end
				S_READ: begin
					state_q <= (item_q.op == OP_EVENT) ? S_EV_B : S_RMW;
				end
				S_RMW: begin
					state_q <= S_IDLE;
				end
				S_EV_B: begin
					// nodes past the table have no flags and no edges
					rown_q  <= node_ok ? mem_rdata : '0;
					state_q <= S_EV_C;
				end
				S_EV_C: begin
					emit_q <= 1'b0;
					scan_q <= '0;
					if (flags_n.entry) begin
						if (active_q) begin
							res_q[0] <= mk_res(KIND_INTERRUPTED, 1'b0, '0, item_q.node, '0, 1'b0);
							res_q[1] <= mk_res(KIND_ENTRY, 1'b1, flags_n.rule, item_q.node,
							                   '0, 1'b1);
						end else begin
							res_q[0] <= mk_res(KIND_ENTRY, 1'b1, flags_n.rule, item_q.node,
							                   '0, 1'b1);
						end
						active_q    <= 1'b1;
						cur_q       <= item_q.node;
						since_q     <= '0;
						thr_valid_q <= 1'b0;
						thr_q       <= '0;
						state_q     <= S_MIN;
					end else if (!active_q) begin
						if (any_n) begin
							res_q[0]    <= mk_res(KIND_ACTIVATED, 1'b0, '0, item_q.node, '0, 1'b1);
							active_q    <= 1'b1;
							cur_q       <= item_q.node;
							since_q     <= '0;
							thr_valid_q <= 1'b0;
							thr_q       <= '0;
							state_q     <= S_MIN;
						end else begin
							state_q <= S_IDLE;
						end
					end else if (found) begin
						res_q[0]    <= mk_res(KIND_COMPLETED, 1'b1, mrule, cur_q,
						                      EL_W'(since_q), 1'b0);
						res_q[1]    <= mk_res(KIND_ACTIVATED, 1'b1, mrule, item_q.node, '0, 1'b1);
						cur_q       <= item_q.node;
						since_q     <= '0;
						thr_valid_q <= 1'b0;
						thr_q       <= '0;
						state_q     <= S_MIN;
					end else if (flags_n.completion) begin
						res_q[0]    <= mk_res(KIND_COMPLETED, 1'b0, '0, item_q.node,
						                      EL_W'(since_q), 1'b1);
						active_q    <= 1'b0;
						cur_q       <= '0;
						since_q     <= '0;
						thr_valid_q <= 1'b0;
						thr_q       <= '0;
						state_q     <= S_EMIT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_MIN: begin
					// one slot per cycle, minimum deadline over valid slots
					if (sedge.valid && (!thr_valid_q || sedge.deadline < thr_q)) begin
						thr_q       <= sedge.deadline;
						thr_valid_q <= 1'b1;
					end
					if (scan_q == SW'(EDGES_PER_NODE - 1)) begin
						state_q <= S_EMIT;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_TICK: begin
					state_q <= S_IDLE;
					if (active_q) begin
						since_q <= since_n;
						if (tick_fire) begin
							res_q[0]    <= mk_res(KIND_TIMEOUT, 1'b0, '0, cur_q,
							                      EL_W'(since_n), 1'b1);
							emit_q      <= 1'b0;
							active_q    <= 1'b0;
							cur_q       <= '0;
							since_q     <= '0;
							thr_valid_q <= 1'b0;
							thr_q       <= '0;
							state_q     <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					if (push_ready) begin
						if (res_q[emit_q].last) begin
							state_q <= S_IDLE;
						end else begin
							emit_q <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
